FILE: sv/abgpc_pkg.sv
// Package with shared types and constants for the affine box grid point counter.
package abgpc_pkg;

  localparam int COORD_W   = 18;
  localparam int EDGE_W    = 4;
  localparam int COUNT_W   = 13;
  localparam int ROW_W     = 64;
  localparam int COORD_FRAC = 8;
  localparam int MAT_FRAC  = 13;
  localparam int TRANS_FRAC = 5;
  localparam int FWD_FRAC  = COORD_FRAC + MAT_FRAC;
  // Forward images: 19-bit coordinate times 16-bit coefficient, three terms, plus translation.
  localparam int FWD_W     = 40;
  // Grid points fit comfortably in 24 signed bits; inverse images in 44.
  localparam int PT_W      = 24;
  localparam int INV_W     = 44;
  localparam int CFG_IDX_W = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  localparam logic [CFG_IDX_W-1:0] REG_FWD_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 3'd5;

  localparam logic [ROW_W-1:0] ROW_X_RST = 64'h2000000000000000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000200000000000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000000020000000;

  typedef enum logic [1:0] {
    FR_IDLE, FR_CORNER, FR_SPAN, FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_WALK, BK_DRAIN, BK_OUT
  } back_state_t;

  // One classified job: start point, per-axis lengths, box bounds, empty and overflow flags.
  typedef struct packed {
    logic signed [PT_W-1:0] st_x;
    logic signed [PT_W-1:0] st_y;
    logic signed [PT_W-1:0] st_z;
    logic [6:0]             cnt_x;
    logic [6:0]             cnt_y;
    logic [6:0]             cnt_z;
    logic                   empty;
    logic                   ovf;
    logic [COORD_W:0]       lo_x;
    logic [COORD_W:0]       lo_y;
    logic [COORD_W:0]       lo_z;
    logic [COORD_W:0]       hi_x;
    logic [COORD_W:0]       hi_y;
    logic [COORD_W:0]       hi_z;
  } job_t;

  function automatic logic signed [15:0] coef(input logic [ROW_W-1:0] row, input int k);
    coef = row[63-16*k -: 16];
  endfunction

  // Floor of a Q.FWD_FRAC value; arithmetic shift floors for both signs.
  function automatic logic signed [PT_W-1:0] floor_fwd(input logic signed [FWD_W-1:0] v);
    logic signed [FWD_W-1:0] s;
    s = v >>> FWD_FRAC;
    floor_fwd = s[PT_W-1:0];
  endfunction

  function automatic logic signed [PT_W-1:0] ceil_fwd(input logic signed [FWD_W-1:0] v);
    logic signed [FWD_W-1:0] n;
    logic signed [FWD_W-1:0] s;
    n = -v;
    s = n >>> FWD_FRAC;
    ceil_fwd = -(s[PT_W-1:0]);
  endfunction

endpackage

FILE: sv/affine_box_grid_point_counter.sv
// Top level of the affine box grid point counter.
//
//   port group | direction | handshake
//   in_*       | input     | in_valid / in_ready, one word is one box
//   out_*      | output    | out_valid / out_ready, one word is one count
//   cfg_*      | input     | cfg_wr_en, no wait
//
// The front loads a box, runs the eight forward images of its corners through
// the corner pipeline, sizes the walk and queues the job before it takes another box.
// The back walks the product of the three clipped spans, one grid point per
// cycle through the single inverse-transform unit.
// A two-word queue lets the front size the next box while the back walks.
// Reset is synchronous and active low; it restores the identity transform.
// A stalled output holds the back; the front keeps going until the queue fills.
module affine_box_grid_point_counter
  import abgpc_pkg::*;
#(
  parameter int MAX_SPAN       = 16,
  parameter int COORD_INT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_corner_x,
  input  logic [COORD_W-1:0]   in_corner_y,
  input  logic [COORD_W-1:0]   in_corner_z,
  input  logic [EDGE_W-1:0]    in_box_edge,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COUNT_W-1:0]   out_point_count,
  output logic                 out_span_overflow,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  logic [ROW_W-1:0] fwd_x_r, fwd_y_r, fwd_z_r, inv_x_r, inv_y_r, inv_z_r;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_x_r <= ROW_X_RST;
      fwd_y_r <= ROW_Y_RST;
      fwd_z_r <= ROW_Z_RST;
      inv_x_r <= ROW_X_RST;
      inv_y_r <= ROW_Y_RST;
      inv_z_r <= ROW_Z_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FWD_X: fwd_x_r <= cfg_data;
        REG_FWD_Y: fwd_y_r <= cfg_data;
        REG_FWD_Z: fwd_z_r <= cfg_data;
        REG_INV_X: inv_x_r <= cfg_data;
        REG_INV_Y: inv_y_r <= cfg_data;
        REG_INV_Z: inv_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_full, q_push, q_pop, q_not_empty;
  job_t q_job, q_head;

  abgpc_front #(.MAX_SPAN(MAX_SPAN), .COORD_INT_BITS(COORD_INT_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_corner_x, .in_corner_y, .in_corner_z,
    .in_box_edge, .fwd_x(fwd_x_r), .fwd_y(fwd_y_r), .fwd_z(fwd_z_r),
    .q_full, .q_push, .q_job
  );

  abgpc_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head_job(q_head)
  );

  abgpc_back u_back (
    .clk, .rst_n, .q_not_empty, .q_head, .q_pop,
    .inv_x(inv_x_r), .inv_y(inv_y_r), .inv_z(inv_z_r),
    .out_valid, .out_ready, .out_point_count, .out_span_overflow
  );

endmodule

FILE: sv/abgpc_queue.sv
// Two-entry job queue between the front and the back.
module abgpc_queue
  import abgpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head_job  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

FILE: sv/abgpc_front.sv
// Front end: accepts a box, maps its corners forward and sizes the walk.
module abgpc_front
  import abgpc_pkg::*;
#(
  parameter int MAX_SPAN       = 16,
  parameter int COORD_INT_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_corner_x,
  input  logic [COORD_W-1:0] in_corner_y,
  input  logic [COORD_W-1:0] in_corner_z,
  input  logic [EDGE_W-1:0]  in_box_edge,
  input  logic [ROW_W-1:0]   fwd_x,
  input  logic [ROW_W-1:0]   fwd_y,
  input  logic [ROW_W-1:0]   fwd_z,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_job
);

  localparam int CB = COORD_INT_BITS + COORD_FRAC;

  front_state_t state_r, state_nxt;
  logic [3:0]   k_r;
  logic [COORD_W:0] lo_r [3];
  logic [COORD_W:0] hi_r [3];
  logic signed [FWD_W-1:0] mn_r [3];
  logic signed [FWD_W-1:0] mx_r [3];
  logic signed [FWD_W-1:0] v_r  [3];
  logic         v_vld_r;
  job_t         job_r;

  logic [ROW_W-1:0] rows [3];
  logic [COORD_W:0] cc [3];
  logic signed [FWD_W-1:0] v_nxt [3];

  assign rows[0] = fwd_x;
  assign rows[1] = fwd_y;
  assign rows[2] = fwd_z;

  assign cc[0] = k_r[2] ? hi_r[0] : lo_r[0];
  assign cc[1] = k_r[1] ? hi_r[1] : lo_r[1];
  assign cc[2] = k_r[0] ? hi_r[2] : lo_r[2];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      v_nxt[d] = FWD_W'(coef(rows[d], 0)) * FWD_W'($signed({1'b0, cc[0]}))
               + FWD_W'(coef(rows[d], 1)) * FWD_W'($signed({1'b0, cc[1]}))
               + FWD_W'(coef(rows[d], 2)) * FWD_W'($signed({1'b0, cc[2]}))
               + (FWD_W'(coef(rows[d], 3)) <<< (FWD_FRAC - TRANS_FRAC));
    end
  end

  assign in_ready = state_r == FR_IDLE;
  assign q_push   = state_r == FR_PUSH && !q_full;
  assign q_job    = job_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE:   if (in_valid) state_nxt = FR_CORNER;
      FR_CORNER: if (k_r == 4'd8 && v_vld_r) state_nxt = FR_SPAN;
      FR_SPAN:   state_nxt = FR_PUSH;
      FR_PUSH:   if (!q_full) state_nxt = FR_IDLE;
      default:   state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      k_r     <= 4'd0;
      v_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FR_IDLE) begin
        k_r     <= 4'd0;
        v_vld_r <= 1'b0;
      end else if (state_r == FR_CORNER) begin
        if (k_r != 4'd8) k_r <= k_r + 4'd1;
        v_vld_r <= k_r != 4'd8;
      end
    end
  end

  // Datapath: product terms are registered, and the min/max fold takes them in the next cycle.
  always_ff @(posedge clk) begin
    logic signed [PT_W-1:0] s;
    if (state_r == FR_IDLE && in_valid) begin
      lo_r[0] <= {1'b0, in_corner_x & COORD_W'((1 << CB) - 1)};
      lo_r[1] <= {1'b0, in_corner_y & COORD_W'((1 << CB) - 1)};
      lo_r[2] <= {1'b0, in_corner_z & COORD_W'((1 << CB) - 1)};
      hi_r[0] <= {1'b0, in_corner_x & COORD_W'((1 << CB) - 1)}
               + ((COORD_W+1)'(in_box_edge) << COORD_FRAC);
      hi_r[1] <= {1'b0, in_corner_y & COORD_W'((1 << CB) - 1)}
               + ((COORD_W+1)'(in_box_edge) << COORD_FRAC);
      hi_r[2] <= {1'b0, in_corner_z & COORD_W'((1 << CB) - 1)}
               + ((COORD_W+1)'(in_box_edge) << COORD_FRAC);
    end
    if (state_r == FR_CORNER) begin
      for (int d = 0; d < 3; d++) begin
        v_r[d] <= v_nxt[d];
        if (v_vld_r) begin
          if (k_r == 4'd1) begin
            mn_r[d] <= v_r[d];
            mx_r[d] <= v_r[d];
          end else begin
            if (v_r[d] < mn_r[d]) mn_r[d] <= v_r[d];
            if (v_r[d] > mx_r[d]) mx_r[d] <= v_r[d];
          end
        end
      end
    end
    if (state_r == FR_SPAN) begin
      for (int d = 0; d < 3; d++) begin
        s = ceil_fwd(mn_r[d]);
        case (d)
          0: job_r.st_x <= s;
          1: job_r.st_y <= s;
          default: job_r.st_z <= s;
        endcase
      end
      // Lengths and the empty and overflow flags; the overflow flag stays set when one axis
      // clips even if another axis is empty.
      begin
        logic signed [PT_W-1:0] nn [3];
        logic [6:0] cl [3];
        logic emp, ov;
        emp = 1'b0;
        ov  = 1'b0;
        for (int d = 0; d < 3; d++) begin
          nn[d] = floor_fwd(mx_r[d]) - ceil_fwd(mn_r[d]) + PT_W'(1);
          if (nn[d] <= 0) begin
            cl[d] = 7'd0;
            emp = 1'b1;
          end else if (nn[d] > PT_W'(MAX_SPAN)) begin
            cl[d] = 7'(MAX_SPAN);
            ov = 1'b1;
          end else begin
            cl[d] = nn[d][6:0];
          end
        end
        job_r.cnt_x <= cl[0];
        job_r.cnt_y <= cl[1];
        job_r.cnt_z <= cl[2];
        job_r.ovf   <= ov;
        job_r.empty <= emp;
      end
      job_r.lo_x <= lo_r[0];
      job_r.lo_y <= lo_r[1];
      job_r.lo_z <= lo_r[2];
      job_r.hi_x <= hi_r[0];
      job_r.hi_y <= hi_r[1];
      job_r.hi_z <= hi_r[2];
    end
  end

endmodule

FILE: sv/abgpc_back.sv
// Back end: walks the grid points of one job and counts inverse hits.
module abgpc_back
  import abgpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  job_t               q_head,
  output logic               q_pop,
  input  logic [ROW_W-1:0]   inv_x,
  input  logic [ROW_W-1:0]   inv_y,
  input  logic [ROW_W-1:0]   inv_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] out_point_count,
  output logic               out_span_overflow
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [6:0]  i_r, j_r, m_r;
  logic        hit_vld_r, hit_r;
  logic [COUNT_W-1:0] count_r;
  logic        last;

  logic [ROW_W-1:0] rows [3];
  logic signed [PT_W-1:0] p [3];
  logic signed [INV_W-1:0] v [3];
  logic signed [INV_W-1:0] lo_s [3];
  logic signed [INV_W-1:0] hi_s [3];
  logic pt_in;

  assign rows[0] = inv_x;
  assign rows[1] = inv_y;
  assign rows[2] = inv_z;
  assign p[0] = job_r.st_x + PT_W'(i_r);
  assign p[1] = job_r.st_y + PT_W'(j_r);
  assign p[2] = job_r.st_z + PT_W'(m_r);
  assign lo_s[0] = INV_W'(job_r.lo_x) <<< (MAT_FRAC - COORD_FRAC);
  assign lo_s[1] = INV_W'(job_r.lo_y) <<< (MAT_FRAC - COORD_FRAC);
  assign lo_s[2] = INV_W'(job_r.lo_z) <<< (MAT_FRAC - COORD_FRAC);
  assign hi_s[0] = INV_W'(job_r.hi_x) <<< (MAT_FRAC - COORD_FRAC);
  assign hi_s[1] = INV_W'(job_r.hi_y) <<< (MAT_FRAC - COORD_FRAC);
  assign hi_s[2] = INV_W'(job_r.hi_z) <<< (MAT_FRAC - COORD_FRAC);

  always_comb begin
    pt_in = 1'b1;
    for (int d = 0; d < 3; d++) begin
      v[d] = INV_W'(coef(rows[d], 0)) * INV_W'(p[0])
           + INV_W'(coef(rows[d], 1)) * INV_W'(p[1])
           + INV_W'(coef(rows[d], 2)) * INV_W'(p[2])
           + (INV_W'(coef(rows[d], 3)) <<< (MAT_FRAC - TRANS_FRAC));
      if (v[d] < lo_s[d] || v[d] > hi_s[d]) pt_in = 1'b0;
    end
  end

  assign last = (m_r == job_r.cnt_z - 7'd1) && (j_r == job_r.cnt_y - 7'd1)
             && (i_r == job_r.cnt_x - 7'd1);
  assign q_pop = state_r == BK_IDLE && q_not_empty;
  assign out_valid = state_r == BK_OUT;
  assign out_point_count = count_r;
  assign out_span_overflow = job_r.ovf;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (q_not_empty) state_nxt = q_head.empty ? BK_DRAIN : BK_WALK;
      BK_WALK:  if (last) state_nxt = BK_DRAIN;
      BK_DRAIN: state_nxt = BK_OUT;
      BK_OUT:   if (out_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      hit_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hit_vld_r <= state_r == BK_WALK;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= pt_in;
    if (q_pop) begin
      job_r   <= q_head;
      i_r     <= 7'd0;
      j_r     <= 7'd0;
      m_r     <= 7'd0;
      count_r <= '0;
    end else begin
      if (state_r == BK_WALK) begin
        if (m_r == job_r.cnt_z - 7'd1) begin
          m_r <= 7'd0;
          if (j_r == job_r.cnt_y - 7'd1) begin
            j_r <= 7'd0;
            i_r <= i_r + 7'd1;
          end else begin
            j_r <= j_r + 7'd1;
          end
        end else begin
          m_r <= m_r + 7'd1;
        end
      end
      if (hit_vld_r && hit_r && count_r != COUNT_MAX) count_r <= count_r + 1'b1;
    end
  end

endmodule

FILE: sv/abgpc_checker.sv
// Port-level checker for the affine box grid point counter, with its bind.
module abgpc_checker
  import abgpc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_point_count,
  input logic               out_span_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_count)
      && $stable(out_span_overflow))
    else $error("result changed while stalled");

  a_in_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took two boxes back to back");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind affine_box_grid_point_counter abgpc_checker u_abgpc_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_point_count, .out_span_overflow
);

FILE: tb/sv/affine_box_grid_point_counter_tb.sv
// Self-checking testbench for the affine box grid point counter.
module tb;
  import abgpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SPAN       = 16;
  localparam int COORD_INT_BITS = 10;
  // Watchdog in clock cycles, several times the slowest correct run.
  localparam longint CYCLE_LIMIT = 20_000_000;
  // Receiver holds off this long once, so the two-word queue fills up.
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [EDGE_W-1:0]  edge_len;
  } box_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } count_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_corner_x = '0;
  logic [COORD_W-1:0]   in_corner_y = '0;
  logic [COORD_W-1:0]   in_corner_z = '0;
  logic [EDGE_W-1:0]    in_box_edge = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COUNT_W-1:0]   out_point_count;
  logic                 out_span_overflow;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FWD_X;
  logic [ROW_W-1:0]     cfg_data = '0;

  affine_box_grid_point_counter #(
    .MAX_SPAN      (MAX_SPAN),
    .COORD_INT_BITS(COORD_INT_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_corner_x      (in_corner_x),
    .in_corner_y      (in_corner_y),
    .in_corner_z      (in_corner_z),
    .in_box_edge      (in_box_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_count  (out_point_count),
    .out_span_overflow(out_span_overflow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the transform registers, and the values staged for the next write.
  logic [ROW_W-1:0] fwd_rows [3];
  logic [ROW_W-1:0] inv_rows [3];
  logic [ROW_W-1:0] staged_rows [6];

  box_t   boxes_pending [$];
  count_t counts_due [$];
  box_t   box_on_bus;
  int     errors = 0;
  int     counts_seen = 0;
  longint cycle_count = 0;

  // Sign-extend one 16-bit field of a row.
  function automatic longint s16(input logic [15:0] w);
    return longint'($signed(w));
  endfunction

  // One row of an affine transform; the translation is scaled up by sh bits.
  function automatic longint apply_row(input logic [ROW_W-1:0] row, input longint a,
                                       input longint b, input longint c, input int sh);
    return s16(row[63:48]) * a + s16(row[47:32]) * b + s16(row[31:16]) * c
         + s16(row[15:0]) * (longint'(1) << sh);
  endfunction

  // Count of grid points in the forward bounding box, clipped to MAX_SPAN per axis, whose
  // inverse image falls inside the source box, saturating at 8191, with the overflow flag.
  function automatic count_t predict_count(input box_t b);
    longint cmask, v, px, py, pz, last;
    longint lo [3];
    longint hi [3];
    longint mn [3];
    longint mx [3];
    longint st [3];
    longint span [3];
    longint cc [3];
    bit     ovf, empty, pt_in;
    int     cnt;
    count_t r;
    cmask = (longint'(1) << (COORD_INT_BITS + COORD_FRAC)) - 1;
    lo[0] = longint'(b.x) & cmask;
    lo[1] = longint'(b.y) & cmask;
    lo[2] = longint'(b.z) & cmask;
    for (int d = 0; d < 3; d++) hi[d] = lo[d] + longint'(b.edge_len) * 256;
    for (int k = 0; k < 8; k++) begin
      cc[0] = (k & 4) ? hi[0] : lo[0];
      cc[1] = (k & 2) ? hi[1] : lo[1];
      cc[2] = (k & 1) ? hi[2] : lo[2];
      for (int d = 0; d < 3; d++) begin
        v = apply_row(fwd_rows[d], cc[0], cc[1], cc[2], FWD_FRAC - TRANS_FRAC);
        if (k == 0 || v < mn[d]) mn[d] = v;
        if (k == 0 || v > mx[d]) mx[d] = v;
      end
    end
    ovf = 1'b0;
    empty = 1'b0;
    for (int d = 0; d < 3; d++) begin
      // Arithmetic shift floors for both signs; ceil is the negated floor of the negation.
      st[d] = -((-mn[d]) >>> FWD_FRAC);
      last = mx[d] >>> FWD_FRAC;
      span[d] = last - st[d] + 1;
      if (span[d] <= 0) begin
        span[d] = 0;
        empty = 1'b1;
      end else if (span[d] > MAX_SPAN) begin
        span[d] = MAX_SPAN;
        ovf = 1'b1;
      end
    end
    cnt = 0;
    if (!empty) begin
      for (longint i = 0; i < span[0]; i++)
        for (longint j = 0; j < span[1]; j++)
          for (longint m = 0; m < span[2]; m++) begin
            px = st[0] + i;
            py = st[1] + j;
            pz = st[2] + m;
            pt_in = 1'b1;
            for (int d = 0; d < 3; d++) begin
              v = apply_row(inv_rows[d], px, py, pz, MAT_FRAC - TRANS_FRAC);
              if (v < lo[d] * 32 || v > hi[d] * 32) pt_in = 1'b0;
            end
            if (pt_in && cnt < 8191) cnt++;
          end
    end
    r.count = cnt[COUNT_W-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: sends boxes in bursts of random length separated by random gaps.
  // The expected count of a box is worked out at the edge where it is accepted,
  // so it always uses the transform that the block holds at that time.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        counts_due.push_back(predict_count(box_on_bus));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (boxes_pending.size() > 0) begin
          box_on_bus = boxes_pending.pop_front();
          in_corner_x <= box_on_bus.x;
          in_corner_y <= box_on_bus.y;
          in_corner_z <= box_on_bus.z;
          in_box_edge <= box_on_bus.edge_len;
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: the stall pattern switches between always ready, light stalls
  // and heavy stalls, and once it holds off for a long stretch.
  int unsigned mode_left = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;
  always @(posedge clk) begin
    count_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        counts_seen++;
        if (counts_due.size() == 0) begin
          $error("count word with no box waiting: count %0d ovf %0b",
                 out_point_count, out_span_overflow);
          errors++;
        end else begin
          want = counts_due.pop_front();
          if (out_point_count !== want.count) begin
            $error("point_count expected %0d actual %0d", want.count, out_point_count);
            errors++;
          end
          if (out_span_overflow !== want.ovf) begin
            $error("span_overflow expected %0b actual %0b", want.ovf, out_span_overflow);
            errors++;
          end
        end
      end
      if (!long_hold_done && counts_seen == 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  function automatic box_t make_box(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                    input logic [COORD_W-1:0] z, input logic [EDGE_W-1:0] e);
    box_t b;
    b.x = x;
    b.y = y;
    b.z = z;
    b.edge_len = e;
    return b;
  endfunction

  // Mostly small boxes keep the walk short; now and then a large one.
  function automatic box_t random_box();
    box_t b;
    b.x = $urandom_range(0, 18'h3FFFF);
    b.y = $urandom_range(0, 18'h3FFFF);
    b.z = $urandom_range(0, 18'h3FFFF);
    // Whole-voxel corners make exact hits on the box bounds likely.
    if ($urandom_range(0, 9) < 3) begin
      b.x[7:0] = '0;
      b.y[7:0] = '0;
      b.z[7:0] = '0;
    end
    b.edge_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    return b;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input int a, input int b, input int c,
                                                input int t);
    return {a[15:0], b[15:0], c[15:0], t[15:0]};
  endfunction

  // Writes the six staged rows, one per cycle; only called while the block is idle.
  task automatic program_regs();
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= staged_rows[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    for (int d = 0; d < 3; d++) begin
      fwd_rows[d] = staged_rows[d];
      inv_rows[d] = staged_rows[d + 3];
    end
  endtask

  // Sender pauses until every count word of the phase has come back. The
  // check runs at the falling edge, after the driver's updates have settled.
  task automatic wait_drained();
    while (boxes_pending.size() != 0 || in_valid || counts_due.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) boxes_pending.push_back(random_box());
  endtask

  // A near-identity transform pair with random skew; the inverse translation
  // roughly undoes the forward one so that many points land inside the box.
  task automatic stage_random_pair();
    int t;
    for (int d = 0; d < 3; d++) begin
      t = $urandom_range(0, 16'hFFFF);
      staged_rows[d] = pack_row((d == 0 ? 32'h2000 : 0) + $urandom_range(0, 16'h1000) - 16'h800,
                                (d == 1 ? 32'h2000 : 0) + $urandom_range(0, 16'h1000) - 16'h800,
                                (d == 2 ? 32'h2000 : 0) + $urandom_range(0, 16'h1000) - 16'h800,
                                t);
      staged_rows[d + 3] = pack_row(
          (d == 0 ? 32'h2000 : 0) + $urandom_range(0, 16'h400) - 16'h200,
          (d == 1 ? 32'h2000 : 0) + $urandom_range(0, 16'h400) - 16'h200,
          (d == 2 ? 32'h2000 : 0) + $urandom_range(0, 16'h400) - 16'h200,
          -t + $urandom_range(0, 64) - 32);
    end
  endtask

  initial begin
    fwd_rows[0] = ROW_X_RST;
    fwd_rows[1] = ROW_Y_RST;
    fwd_rows[2] = ROW_Z_RST;
    inv_rows[0] = ROW_X_RST;
    inv_rows[1] = ROW_Y_RST;
    inv_rows[2] = ROW_Z_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed boxes under the reset identity transform.
    boxes_pending.push_back(make_box(18'h00000, 18'h00000, 18'h00000, 4'd0));
    boxes_pending.push_back(make_box(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 4'd15));
    boxes_pending.push_back(make_box(18'h00000, 18'h00000, 18'h00000, 4'd15));
    boxes_pending.push_back(make_box(18'h3FF00, 18'h3FF00, 18'h3FF00, 4'd0));
    // Zero edge off the grid: the span is empty on every axis.
    boxes_pending.push_back(make_box(18'h00080, 18'h00180, 18'h00201, 4'd0));
    // Zero edge off the grid on one axis only.
    boxes_pending.push_back(make_box(18'h00100, 18'h00200, 18'h000FF, 4'd0));
    boxes_pending.push_back(make_box(18'h2AAAA, 18'h15555, 18'h2AAAA, 4'd5));
    boxes_pending.push_back(make_box(18'h15555, 18'h2AAAA, 18'h15555, 4'd10));
    boxes_pending.push_back(make_box(18'h00100, 18'h00100, 18'h00100, 4'd1));
    boxes_pending.push_back(make_box(18'h000FF, 18'h00001, 18'h00080, 4'd3));
    boxes_pending.push_back(make_box(18'h12345, 18'h0ABCD, 18'h30000, 4'd8));
    wait_drained();

    // Extreme coefficients and translations; spans clip on wide boxes.
    staged_rows[0] = pack_row(32'h8000, 32'h8000, 32'h8000, 32'h8000);
    staged_rows[1] = pack_row(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
    staged_rows[2] = 64'h0;
    staged_rows[3] = pack_row(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
    staged_rows[4] = pack_row(32'h8000, 32'h8000, 32'h8000, 32'h8000);
    staged_rows[5] = 64'hFFFF_FFFF_FFFF_FFFF;
    program_regs();
    boxes_pending.push_back(make_box(18'h00000, 18'h00000, 18'h00000, 4'd0));
    boxes_pending.push_back(make_box(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 4'd1));
    boxes_pending.push_back(make_box(18'h00000, 18'h3FFFF, 18'h00000, 4'd15));
    boxes_pending.push_back(make_box(18'h3FFFF, 18'h00000, 18'h3FFFF, 4'd15));
    boxes_pending.push_back(make_box(18'h00100, 18'h00200, 18'h00300, 4'd0));
    for (int i = 0; i < 10; i++) begin
      box_t b;
      b = random_box();
      b.edge_len = $urandom_range(0, 1);
      boxes_pending.push_back(b);
    end
    wait_drained();

    // Scale by two with its exact inverse; wide boxes overflow the span.
    staged_rows[0] = pack_row(32'h4000, 0, 0, 0);
    staged_rows[1] = pack_row(0, 32'h4000, 0, 0);
    staged_rows[2] = pack_row(0, 0, 32'h4000, 0);
    staged_rows[3] = pack_row(32'h1000, 0, 0, 0);
    staged_rows[4] = pack_row(0, 32'h1000, 0, 0);
    staged_rows[5] = pack_row(0, 0, 32'h1000, 0);
    program_regs();
    boxes_pending.push_back(make_box(18'h00100, 18'h00100, 18'h00100, 4'd8));
    boxes_pending.push_back(make_box(18'h00000, 18'h00000, 18'h00000, 4'd7));
    queue_random(200);
    wait_drained();

    // Axis swap with negation and translation, and its exact inverse.
    staged_rows[0] = pack_row(0, 32'hE000, 0, 32'h1000);
    staged_rows[1] = pack_row(32'h2000, 0, 0, 32'hF800);
    staged_rows[2] = pack_row(0, 0, 32'hE000, 32'h7FFF);
    staged_rows[3] = pack_row(0, 32'h2000, 0, 32'h0800);
    staged_rows[4] = pack_row(32'hE000, 0, 0, 32'h1000);
    staged_rows[5] = pack_row(0, 0, 32'hE000, 32'h7FFF);
    program_regs();
    queue_random(200);
    wait_drained();

    // Random near-identity pairs.
    for (int ph = 0; ph < 6; ph++) begin
      stage_random_pair();
      program_regs();
      queue_random(200);
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: affine_box_grid_point_counter.f
sv/abgpc_pkg.sv
sv/abgpc_queue.sv
sv/abgpc_front.sv
sv/abgpc_back.sv
sv/affine_box_grid_point_counter.sv
sv/abgpc_checker.sv
tb/sv/affine_box_grid_point_counter_tb.sv
